/* rtl/cbt_pkg.sv */
// Shared widths, register indexes and divider interface types of the baseline tracker.
package cbt_pkg;

   localparam int SAMPLE_WIDTH = 24;
   localparam int DELTA_WIDTH  = SAMPLE_WIDTH + 1;
   localparam int STEP_WIDTH   = SAMPLE_WIDTH + 2;
   localparam int NSUM_WIDTH   = SAMPLE_WIDTH + 3;
   localparam int COUNT_WIDTH  = 32;
   localparam int RUN_WIDTH    = 16;
   localparam int RATE_WIDTH   = 17;
   localparam int RATE_SHIFT   = 16;
   localparam int PROD_WIDTH   = DELTA_WIDTH + RATE_WIDTH;
   localparam int CSR_WIDTH    = 24;
   localparam int CSR_IDX_WIDTH = 3;

   localparam int DIV_STEPS     = NSUM_WIDTH;
   localparam int DIV_CNT_WIDTH = $clog2(DIV_STEPS + 1);

   localparam logic [RATE_WIDTH-1:0]  RATE_ONE  = RATE_WIDTH'(1 << RATE_SHIFT);
   localparam logic [RUN_WIDTH-1:0]   RUN_MAX   = '1;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   // divide by five as a multiply by ceil(2^NOISE_SHIFT / 5); exact for any
   // dividend below 2^NSUM_WIDTH
   localparam int NOISE_DIVISOR = 5;
   localparam int NOISE_SHIFT   = NSUM_WIDTH + 2;
   localparam logic [NSUM_WIDTH-1:0] NOISE_RECIP =
      NSUM_WIDTH'((longint'(1) << NOISE_SHIFT) / NOISE_DIVISOR + 1);

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_WARMUP   = CSR_IDX_WIDTH'(0);
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_MIN_STBL = CSR_IDX_WIDTH'(1);
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_MAX_NOISE = CSR_IDX_WIDTH'(2);
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_LRN_RATE = CSR_IDX_WIDTH'(3);
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_DRIFT_LIM = CSR_IDX_WIDTH'(4);

   typedef struct packed {
      logic                   start;
      logic [NSUM_WIDTH-1:0]  dividend;
      logic [COUNT_WIDTH-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                  done;
      logic [NSUM_WIDTH-1:0] quotient;
   } div_rsp_type;

endpackage

/* rtl/cbt_div.sv */
// Restoring divider, one quotient bit per cycle, unsigned.
module cbt_div (
   input  logic                 clock,
   input  logic                 reset,
   input  cbt_pkg::div_req_type req,
   output cbt_pkg::div_rsp_type rsp
);

   logic [cbt_pkg::COUNT_WIDTH-1:0]   rem_ff, rem_in;
   logic [cbt_pkg::NSUM_WIDTH-1:0]    quo_ff, quo_in;
   logic [cbt_pkg::COUNT_WIDTH-1:0]   dvs_ff, dvs_in;
   logic [cbt_pkg::DIV_CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                              done_ff, done_in;
   logic [cbt_pkg::COUNT_WIDTH:0]     trial;
   logic [cbt_pkg::COUNT_WIDTH:0]     diff;

   always_comb begin
      trial   = {rem_ff, quo_ff[cbt_pkg::NSUM_WIDTH-1]};
      diff    = trial - {1'b0, dvs_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (req.start) begin
         rem_in = '0;
         quo_in = req.dividend;
         dvs_in = req.divisor;
         cnt_in = cbt_pkg::DIV_CNT_WIDTH'(cbt_pkg::DIV_STEPS);
      end else if (cnt_ff != '0) begin
         if (!diff[cbt_pkg::COUNT_WIDTH]) begin
            rem_in = diff[cbt_pkg::COUNT_WIDTH-1:0];
            quo_in = {quo_ff[cbt_pkg::NSUM_WIDTH-2:0], 1'b1};
         end else begin
            rem_in = trial[cbt_pkg::COUNT_WIDTH-1:0];
            quo_in = {quo_ff[cbt_pkg::NSUM_WIDTH-2:0], 1'b0};
         end
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == cbt_pkg::DIV_CNT_WIDTH'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

/* rtl/capacitance_baseline_tracker.sv */
// Capacitance baseline tracker: baseline, noise and drift tracking with learning phase.
// Sequence from accept: restart, bad or first sample EVAL, DONE; learned sample EVAL, NOISE,
// MUL, APPLY, DONE (NOISE, DONE when over a limit); learning-phase sample EVAL, NOISE, LDIV,
// DONE, waiting in LDIV for the 27-step divider. Throughput: one word at a time; req_stall stays
// high until the result is loaded, and a stalled result holds the sequencer in its last state.
// Reset (synchronous, active high) clears tracked state and loads register defaults.
module capacitance_baseline_tracker (
   input  logic                                     clock,
   input  logic                                     reset,
   // input words
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic                                     req_action,
   input  logic signed [cbt_pkg::SAMPLE_WIDTH-1:0]  req_sample_pf,
   input  logic                                     req_sample_bad,
   // result words
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic                                     rsp_accepted,
   output logic                                     rsp_learned,
   output logic signed [cbt_pkg::SAMPLE_WIDTH-1:0]  rsp_baseline_pf,
   output logic        [cbt_pkg::SAMPLE_WIDTH-1:0]  rsp_noise_pf,
   output logic signed [cbt_pkg::DELTA_WIDTH-1:0]   rsp_drift_pf,
   output logic        [cbt_pkg::COUNT_WIDTH-1:0]   rsp_sample_total,
   // configuration
   input  logic                                     csr_wr_en,
   input  logic [cbt_pkg::CSR_IDX_WIDTH-1:0]        csr_index,
   input  logic [cbt_pkg::CSR_WIDTH-1:0]            csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_EVAL, ST_NOISE, ST_LDIV, ST_MUL, ST_APPLY, ST_DONE
   } state_type;

   localparam int SW = cbt_pkg::SAMPLE_WIDTH;
   localparam int DW = cbt_pkg::DELTA_WIDTH;
   localparam int TW = cbt_pkg::STEP_WIDTH;
   localparam int NW = cbt_pkg::NSUM_WIDTH;
   localparam int CW = cbt_pkg::COUNT_WIDTH;
   localparam int RW = cbt_pkg::RUN_WIDTH;
   localparam int PW = cbt_pkg::PROD_WIDTH;
   localparam int LW = cbt_pkg::RATE_WIDTH;

   // ---------------------------------------------------------------- config regs
   logic [RW-1:0] warmup_ff, min_stable_ff;
   logic [SW-1:0] max_noise_ff, drift_limit_ff;
   logic [LW-1:0] lrn_rate_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         warmup_ff      <= RW'(16);
         min_stable_ff  <= RW'(8);
         max_noise_ff   <= SW'(6554);
         lrn_rate_ff    <= LW'(3277);
         drift_limit_ff <= SW'(65536);
      end else if (csr_wr_en) begin
         case (csr_index)
            cbt_pkg::CSR_WARMUP:    warmup_ff      <= csr_wdata[RW-1:0];
            cbt_pkg::CSR_MIN_STBL:  min_stable_ff  <= csr_wdata[RW-1:0];
            cbt_pkg::CSR_MAX_NOISE: max_noise_ff   <= csr_wdata[SW-1:0];
            cbt_pkg::CSR_LRN_RATE:  lrn_rate_ff    <= csr_wdata[LW-1:0];
            cbt_pkg::CSR_DRIFT_LIM: drift_limit_ff <= csr_wdata[SW-1:0];
            default: ;
         endcase
      end
   end

   // zero counts act as one, rates above one act as one
   logic [RW-1:0] warm_eff, need_eff;
   logic [LW-1:0] rate_eff;
   assign warm_eff = (warmup_ff == '0) ? RW'(1) : warmup_ff;
   assign need_eff = (min_stable_ff == '0) ? RW'(1) : min_stable_ff;
   assign rate_eff = (lrn_rate_ff > cbt_pkg::RATE_ONE) ? cbt_pkg::RATE_ONE : lrn_rate_ff;

   // ---------------------------------------------------------------- state
   state_type            state_ff, state_in;
   logic                 action_ff, action_in;
   logic                 bad_ff, bad_in;
   logic signed [SW-1:0] sample_ff, sample_in;
   logic signed [SW-1:0] baseline_ff, baseline_in;
   logic [SW-1:0]        noise_ff, noise_in;
   logic signed [DW-1:0] drift_ff, drift_in;
   logic [CW-1:0]        seen_ff, seen_in;
   logic [RW-1:0]        run_ff, run_in;
   logic                 learned_ff, learned_in;
   logic                 acc_ff, acc_in;
   logic [DW-1:0]        ad_ff, ad_in;
   logic [PW-1:0]        prod_ff, prod_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_acc_ff, rsp_acc_in;
   logic                 rsp_lrn_ff, rsp_lrn_in;
   logic signed [SW-1:0] rsp_base_ff, rsp_base_in;
   logic [SW-1:0]        rsp_noise_ff, rsp_noise_in;
   logic signed [DW-1:0] rsp_drift_ff, rsp_drift_in;
   logic [CW-1:0]        rsp_total_ff, rsp_total_in;

   cbt_pkg::div_req_type div_req;
   cbt_pkg::div_rsp_type div_rsp;

   cbt_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // ---------------------------------------------------------------- datapath
   logic signed [DW-1:0]                 delta;
   logic [DW-1:0]                        delta_abs;
   logic [NW-1:0]                        noise_sum;
   logic [cbt_pkg::NOISE_SHIFT+SW-1:0]   noise_prod;
   logic [SW-1:0]                        noise_quot;
   logic [DW-1:0]                        step_mag;
   logic signed [TW-1:0]                 step_signed;
   logic signed [TW-1:0]                 base_sum;
   logic                                 stable_hit;
   logic [RW-1:0]                        run_next;
   logic                                 out_free;

   assign delta     = DW'(sample_ff) - DW'(baseline_ff);
   assign delta_abs = delta[DW-1] ? DW'(-delta) : DW'(delta);
   // 4*noise + |delta| over five, by reciprocal multiply; never exceeds the noise width
   assign noise_sum  = {1'b0, noise_ff, 2'b00} + NW'(ad_ff);
   assign noise_prod = noise_sum * cbt_pkg::NOISE_RECIP;
   assign noise_quot = noise_prod[cbt_pkg::NOISE_SHIFT +: SW];

   // step magnitude: quotient while learning, scaled product once learned
   assign step_mag    = (state_ff == ST_APPLY) ? prod_ff[cbt_pkg::RATE_SHIFT +: DW]
                                               : div_rsp.quotient[DW-1:0];
   // sign of the step follows delta (drift_ff holds it)
   assign step_signed = drift_ff[DW-1] ? -$signed({1'b0, step_mag})
                                       :  $signed({1'b0, step_mag});
   assign base_sum    = TW'(baseline_ff) + step_signed;

   assign stable_hit = (seen_ff >= CW'(warm_eff)) && (ad_ff <= DW'(max_noise_ff));
   assign run_next   = !stable_hit ? '0 :
                       (run_ff == cbt_pkg::RUN_MAX) ? run_ff : run_ff + 1'b1;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in    = state_ff;
      action_in   = action_ff;
      bad_in      = bad_ff;
      sample_in   = sample_ff;
      baseline_in = baseline_ff;
      noise_in    = noise_ff;
      drift_in    = drift_ff;
      seen_in     = seen_ff;
      run_in      = run_ff;
      learned_in  = learned_ff;
      acc_in      = acc_ff;
      ad_in       = ad_ff;
      prod_in     = prod_ff;

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_acc_in   = rsp_acc_ff;
      rsp_lrn_in   = rsp_lrn_ff;
      rsp_base_in  = rsp_base_ff;
      rsp_noise_in = rsp_noise_ff;
      rsp_drift_in = rsp_drift_ff;
      rsp_total_in = rsp_total_ff;

      // learning step: |delta| / sample count
      div_req.start    = 1'b0;
      div_req.dividend = NW'(ad_ff);
      div_req.divisor  = seen_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               action_in = req_action;
               bad_in    = req_sample_bad;
               sample_in = req_sample_pf;
               state_in  = ST_EVAL;
            end
         end
         ST_EVAL: begin
            acc_in   = 1'b0;
            state_in = ST_DONE;
            if (action_ff) begin
               // restart clears everything tracked
               baseline_in = '0;
               noise_in    = '0;
               drift_in    = '0;
               seen_in     = '0;
               run_in      = '0;
               learned_in  = 1'b0;
            end else if (!bad_ff) begin
               seen_in = (seen_ff == cbt_pkg::COUNT_MAX) ? seen_ff : seen_ff + 1'b1;
               if (seen_ff == '0) begin
                  // first sample seeds the baseline
                  baseline_in = sample_ff;
                  noise_in    = '0;
                  drift_in    = '0;
               end else begin
                  drift_in = delta;
                  ad_in    = delta_abs;
                  state_in = ST_NOISE;
               end
            end
         end
         ST_NOISE: begin
            noise_in = noise_quot;
            if (!learned_ff) begin
               div_req.start = 1'b1;
               state_in      = ST_LDIV;
            end else if (ad_ff > DW'(drift_limit_ff) || ad_ff > DW'(max_noise_ff)) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = PW'(ad_ff) * PW'(rate_eff);
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            baseline_in = base_sum[SW-1:0];
            acc_in      = 1'b1;
            state_in    = ST_DONE;
         end
         ST_LDIV: begin
            if (div_rsp.done) begin
               baseline_in = base_sum[SW-1:0];
               run_in      = run_next;
               if (run_next >= need_eff) begin
                  learned_in = 1'b1;
                  acc_in     = 1'b1;
               end
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_acc_in   = acc_ff;
               rsp_lrn_in   = learned_ff;
               rsp_base_in  = baseline_ff;
               rsp_noise_in = noise_ff;
               rsp_drift_in = drift_ff;
               rsp_total_in = seen_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         baseline_ff  <= '0;
         noise_ff     <= '0;
         drift_ff     <= '0;
         seen_ff      <= '0;
         run_ff       <= '0;
         learned_ff   <= 1'b0;
         acc_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         baseline_ff  <= baseline_in;
         noise_ff     <= noise_in;
         drift_ff     <= drift_in;
         seen_ff      <= seen_in;
         run_ff       <= run_in;
         learned_ff   <= learned_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      action_ff    <= action_in;
      bad_ff       <= bad_in;
      sample_ff    <= sample_in;
      ad_ff        <= ad_in;
      prod_ff      <= prod_in;
      rsp_acc_ff   <= rsp_acc_in;
      rsp_lrn_ff   <= rsp_lrn_in;
      rsp_base_ff  <= rsp_base_in;
      rsp_noise_ff <= rsp_noise_in;
      rsp_drift_ff <= rsp_drift_in;
      rsp_total_ff <= rsp_total_in;
   end

   // ---------------------------------------------------------------- ports
   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_accepted     = rsp_acc_ff;
   assign rsp_learned      = rsp_lrn_ff;
   assign rsp_baseline_pf  = rsp_base_ff;
   assign rsp_noise_pf     = rsp_noise_ff;
   assign rsp_drift_pf     = rsp_drift_ff;
   assign rsp_sample_total = rsp_total_ff;

   // ---------------------------------------------------------------- checks
   // an accepted word only comes with learning done
   a_acc_learned: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_accepted |-> rsp_learned)
      else $error("accepted without learned");

   // learning needs at least the seed sample plus one more
   a_learn_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_learned |-> rsp_sample_total > CW'(1))
      else $error("learned before two samples");

   // divider results only land while the sequencer waits for them
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> state_ff == ST_LDIV)
      else $error("divider done outside a wait state");

endmodule
